/* rtl/ljnb_pkg.sv */
package ljnb_pkg;

	// Default sizes.
	localparam int PARTICLES_DEF = 64;
	localparam int FRAC_BITS_DEF = 16;

	// Fraction bits of the inverse-distance powers.
	localparam int INV_Q = 28;

	// Operand width of the shared multiplier and its digit width per cycle.
	localparam int MUL_W   = 48;
	localparam int DIGIT_W = 16;
	localparam int DIGITS  = MUL_W / DIGIT_W;

	// Time step constants in Q32: dt, dt/2 and dt^2/2.
	localparam logic [25:0] DT_Q32       = 26'd42949673;
	localparam logic [25:0] HALF_DT_Q32  = 26'd21474836;
	localparam logic [25:0] HALF_DT2_Q32 = 26'd214748;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic               in_last;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_pos_z;
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic signed [31:0] new_vel_z;
		logic               out_last;
	} out_item_t;

	// One stored particle vector and one force vector.
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec3_t;

	typedef struct packed {
		logic signed [47:0] x;
		logic signed [47:0] y;
		logic signed [47:0] z;
	} force3_t;

endpackage

/* rtl/lennard_jones_nbody_timestep.sv */
// Loading takes one particle per cycle. The item marked last starts the run, during which busy
// stays high: the configured steps run, then the n results follow. A pair is costly because
// one 48x16 multiplier, which builds each product from digit products, and a one-bit-per-cycle
// restoring divider do all the arithmetic. Reset is asynchronous and active low: it clears
// the sequencer, the particle count and the force valid bits, and sets num_steps to 1. Results
// are strobed once and cannot be stalled.
module lennard_jones_nbody_timestep #(
	parameter int PARTICLES = ljnb_pkg::PARTICLES_DEF,
	parameter int FRAC_BITS = ljnb_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ljnb_pkg::in_item_t item,
	output logic               result_strobe,
	output ljnb_pkg::out_item_t result,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata
);

	localparam int IW    = $clog2(PARTICLES);
	localparam int CW    = $clog2(PARTICLES + 1);
	localparam int MW    = ljnb_pkg::MUL_W;
	localparam int DW    = ljnb_pkg::DIGIT_W;
	localparam int PW    = 2 * MW;
	localparam int IQ    = ljnb_pkg::INV_Q;
	localparam int R2W   = 66 - FRAC_BITS;
	localparam int DIVN  = IQ + FRAC_BITS + 1;
	localparam int DCW   = $clog2(DIVN);
	localparam int INVW  = IQ + 2;
	localparam int R4W   = IQ + 3;
	localparam int R8W   = IQ + 5;
	localparam int TW    = IQ + 7;
	localparam int R14W  = IQ + 8;
	localparam logic [R2W-1:0] R2_MIN = R2W'(1) << (FRAC_BITS - 1);
	localparam logic signed [48:0] F48_MAX = 49'sd140737488355327;
	localparam logic signed [48:0] F48_MIN = -49'sd140737488355328;
	localparam logic signed [48:0] P32_MAX = 49'sd2147483647;
	localparam logic signed [48:0] P32_MIN = -49'sd2147483648;

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_STEP = 14'b00000000000010,
		S_PRD  = 14'b00000000000100,
		S_DIFF = 14'b00000000001000,
		S_MUL  = 14'b00000000010000,
		S_POST = 14'b00000000100000,
		S_DIV  = 14'b00000001000000,
		S_FRD  = 14'b00000010000000,
		S_FWR  = 14'b00000100000000,
		S_ARD  = 14'b00001000000000,
		S_ALD  = 14'b00010000000000,
		S_AWR  = 14'b00100000000000,
		S_ORD  = 14'b01000000000000,
		S_OUT  = 14'b10000000000000
	} state_t;

	typedef enum logic [3:0] {
		OP_SQX, OP_SQY, OP_SQZ, OP_R4, OP_R8, OP_R12, OP_R14,
		OP_FX, OP_FY, OP_FZ, OP_KICK, OP_DV, OP_DA
	} op_t;

	function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
		if (v > P32_MAX) return 32'sh7fffffff;
		else if (v < P32_MIN) return 32'sh80000000;
		else return v[31:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
		if (v > F48_MAX) return 48'sh7fffffffffff;
		else if (v < F48_MIN) return 48'sh800000000000;
		else return v[47:0];
	endfunction

	function automatic logic [47:0] mag48(input logic signed [47:0] a);
		logic [48:0] t;
		t = a[47] ? -49'(a) : 49'(a);
		return t[47:0];
	endfunction

	// Control registers.
	state_t           state_q;
	op_t              op_q;
	logic [1:0]       mulk_q;
	logic [DCW-1:0]   dcnt_q;
	logic [1:0]       comp_q;
	logic             fsel_q;
	logic [IW-1:0]    i_q, j_q;
	logic [CW-1:0]    cnt_q, n_q;
	logic [15:0]      step_q, num_steps_q;
	logic [PARTICLES-1:0] fvalid_q;
	logic             fvld_q;
	logic             strobe_q;

	// Datapath registers.
	logic [PW-1:0]        acc_q;
	logic signed [32:0]   d_q [3];
	logic [R2W-1:0]       r2_q, rem_q;
	logic [INVW-1:0]      inv_q;
	logic [R4W-1:0]       r4_q;
	logic [R8W-1:0]       r8_q;
	logic [TW-1:0]        t_q;
	logic signed [43:0]   c_q;
	logic signed [47:0]   f_q [3];
	logic signed [31:0]   px_q [3];
	logic signed [31:0]   vl_q [3];
	logic signed [47:0]   ac_q [3];
	logic signed [47:0]   kick_q, sv_q;
	ljnb_pkg::out_item_t  result_q;

	// Particle and force memories with registered reads.
	ljnb_pkg::vec3_t   pos_mem [PARTICLES];
	ljnb_pkg::vec3_t   vel_mem [PARTICLES];
	ljnb_pkg::force3_t frc_mem [PARTICLES];
	ljnb_pkg::vec3_t   rda_q, rdb_q, vrd_q;
	ljnb_pkg::force3_t frd_q;

	logic              accept;
	logic              room;
	logic              pv_we, frc_we;
	logic [IW-1:0]     pv_wa, faddr;
	ljnb_pkg::vec3_t   pos_wd, vel_wd;
	ljnb_pkg::force3_t frc_wd;

	assign busy          = (state_q != S_IDLE);
	assign accept        = start && (state_q == S_IDLE);
	assign room          = (cnt_q < CW'(PARTICLES));
	assign result_strobe = strobe_q;
	assign result        = result_q;
	assign faddr         = fsel_q ? j_q : i_q;

	// Loop end tests.
	logic last_j, last_i, last_adv;
	assign last_j   = (CW'(j_q) + CW'(1)) == n_q;
	assign last_i   = (CW'(i_q) + CW'(2)) == n_q;
	assign last_adv = (CW'(i_q) + CW'(1)) == n_q;

	// Shared multiplier: one 48x16 digit product added per cycle.
	logic [MW-1:0] mul_a, mul_b;
	logic [DW-1:0] mul_dig;
	logic [63:0]   pp;
	logic [PW-1:0] pp_sh;
	logic [31:0]   dmag [3];
	logic [42:0]   cmag;
	logic [47:0]   amag;
	logic [31:0]   vmag;

	always_comb begin
		logic [32:0] td;
		logic [43:0] tc;
		logic [32:0] tv;
		for (int k = 0; k < 3; k++) begin
			td      = d_q[k][32] ? -d_q[k] : d_q[k];
			dmag[k] = td[31:0];
		end
		tc   = c_q[43] ? -c_q : c_q;
		cmag = tc[42:0];
		amag = mag48(ac_q[comp_q]);
		tv   = vl_q[comp_q][31] ? -33'(vl_q[comp_q]) : 33'(vl_q[comp_q]);
		vmag = tv[31:0];
	end

	// Operands of the current operation.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op_q)
			OP_SQX:  begin mul_a = MW'(dmag[0]); mul_b = MW'(dmag[0]); end
			OP_SQY:  begin mul_a = MW'(dmag[1]); mul_b = MW'(dmag[1]); end
			OP_SQZ:  begin mul_a = MW'(dmag[2]); mul_b = MW'(dmag[2]); end
			OP_R4:   begin mul_a = MW'(inv_q); mul_b = MW'(inv_q); end
			OP_R8:   begin mul_a = MW'(r4_q); mul_b = MW'(r4_q); end
			OP_R12:  begin mul_a = MW'(r8_q); mul_b = MW'(r4_q); end
			OP_R14:  begin mul_a = MW'(t_q); mul_b = MW'(inv_q); end
			OP_FX:   begin mul_a = MW'(cmag); mul_b = MW'(dmag[0]); end
			OP_FY:   begin mul_a = MW'(cmag); mul_b = MW'(dmag[1]); end
			OP_FZ:   begin mul_a = MW'(cmag); mul_b = MW'(dmag[2]); end
			OP_KICK: begin mul_a = amag; mul_b = MW'(ljnb_pkg::HALF_DT_Q32); end
			OP_DV:   begin mul_a = MW'(vmag); mul_b = MW'(ljnb_pkg::DT_Q32); end
			OP_DA:   begin mul_a = amag; mul_b = MW'(ljnb_pkg::HALF_DT2_Q32); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		case (mulk_q)
			2'd0:    mul_dig = mul_b[DW-1:0];
			2'd1:    mul_dig = mul_b[2*DW-1:DW];
			default: mul_dig = mul_b[3*DW-1:2*DW];
		endcase
		pp = mul_a * mul_dig;
		case (mulk_q)
			2'd0:    pp_sh = {32'b0, pp};
			2'd1:    pp_sh = {16'b0, pp, 16'b0};
			default: pp_sh = {pp, 32'b0};
		endcase
	end

	// Post-processing of a finished product.
	logic [PW-1:0]      sh_f, sh_q;
	logic [R2W-1:0]     sq, r2_sum;
	logic [R14W-1:0]    r14;
	logic [43:0]        c_calc;
	logic [46:0]        fm;
	logic signed [47:0] fval, scm, sc;
	logic               pair_neg, sc_neg;

	always_comb begin
		sh_f   = acc_q >> FRAC_BITS;
		sh_q   = acc_q >> IQ;
		sq     = sh_f[R2W-1:0];
		r2_sum = r2_q + sq;
		r14    = sh_q[R14W-1:0];
		c_calc = (44'(r14) << 5) + (44'(r14) << 4) - (44'(r8_q) << 4) - (44'(r8_q) << 3);
		fm     = (|sh_q[PW-1:47]) ? {47{1'b1}} : sh_q[46:0];
		case (op_q)
			OP_FY:   pair_neg = c_q[43] ^ d_q[1][32];
			OP_FZ:   pair_neg = c_q[43] ^ d_q[2][32];
			default: pair_neg = c_q[43] ^ d_q[0][32];
		endcase
		fval   = pair_neg ? -$signed({1'b0, fm}) : $signed({1'b0, fm});
		scm    = $signed(acc_q[79:32]);
		sc_neg = (op_q == OP_DV) ? vl_q[comp_q][31] : ac_q[comp_q][47];
		sc     = sc_neg ? -scm : scm;
	end

	// Divider step: one quotient bit of 2^(INV_Q+FRAC_BITS) / r2 per cycle.
	logic [R2W:0]   div_sh;
	logic           div_ge;
	logic [R2W-1:0] rem_in;
	always_comb begin
		rem_in = (dcnt_q == '0) ? '0 : rem_q;
		div_sh = {rem_in, (dcnt_q == '0)};
		div_ge = div_sh >= {1'b0, r2_q};
	end

	// Memory write ports.
	always_comb begin
		pv_we  = 1'b0;
		pv_wa  = i_q;
		pos_wd = '{x: px_q[0], y: px_q[1], z: px_q[2]};
		vel_wd = '{x: vl_q[0], y: vl_q[1], z: vl_q[2]};
		if (accept && room) begin
			pv_we  = 1'b1;
			pv_wa  = cnt_q[IW-1:0];
			pos_wd = '{x: item.pos_x, y: item.pos_y, z: item.pos_z};
			vel_wd = '{x: item.vel_x, y: item.vel_y, z: item.vel_z};
		end else if (state_q == S_AWR) begin
			pv_we = 1'b1;
		end
	end

	always_comb begin
		ljnb_pkg::force3_t base;
		base   = fvld_q ? frd_q : '0;
		frc_we = (state_q == S_FWR);
		if (fsel_q) begin
			frc_wd.x = sat48(49'(base.x) - 49'(f_q[0]));
			frc_wd.y = sat48(49'(base.y) - 49'(f_q[1]));
			frc_wd.z = sat48(49'(base.z) - 49'(f_q[2]));
		end else begin
			frc_wd.x = sat48(49'(base.x) + 49'(f_q[0]));
			frc_wd.y = sat48(49'(base.y) + 49'(f_q[1]));
			frc_wd.z = sat48(49'(base.z) + 49'(f_q[2]));
		end
	end

	// Memories.
	always_ff @(posedge clk) begin
		if (pv_we) begin
			pos_mem[pv_wa] <= pos_wd;
			vel_mem[pv_wa] <= vel_wd;
		end
		if (frc_we) begin
			frc_mem[faddr] <= frc_wd;
		end
		rda_q <= pos_mem[i_q];
		rdb_q <= pos_mem[j_q];
		vrd_q <= vel_mem[i_q];
		frd_q <= frc_mem[faddr];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_SQX;
			mulk_q      <= '0;
			dcnt_q      <= '0;
			comp_q      <= '0;
			fsel_q      <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			cnt_q       <= '0;
			n_q         <= '0;
			step_q      <= '0;
			num_steps_q <= 16'd1;
			fvalid_q    <= '0;
			fvld_q      <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			fvld_q   <= fvalid_q[faddr];
			if (cfg_we) begin
				num_steps_q <= cfg_wdata;
			end
			if (frc_we) begin
				fvalid_q[faddr] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.in_last) begin
							n_q     <= cnt_q + CW'(room);
							cnt_q   <= '0;
							step_q  <= '0;
							state_q <= S_STEP;
						end else if (room) begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				S_STEP: begin
					fvalid_q <= '0;
					i_q      <= '0;
					j_q      <= IW'(1);
					fsel_q   <= 1'b0;
					if (step_q == num_steps_q) begin
						state_q <= S_ORD;
					end else if (n_q >= CW'(2)) begin
						state_q <= S_PRD;
					end else begin
						state_q <= S_ARD;
					end
				end
				S_PRD: begin
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					op_q    <= OP_SQX;
					mulk_q  <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					mulk_q <= mulk_q + 2'd1;
					if (mulk_q == 2'(ljnb_pkg::DIGITS - 1)) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					mulk_q  <= '0;
					state_q <= S_MUL;
					case (op_q)
						OP_SQX:  op_q <= OP_SQY;
						OP_SQY:  op_q <= OP_SQZ;
						OP_SQZ: begin
							dcnt_q  <= '0;
							state_q <= S_DIV;
						end
						OP_R4:   op_q <= OP_R8;
						OP_R8:   op_q <= OP_R12;
						OP_R12:  op_q <= OP_R14;
						OP_R14:  op_q <= OP_FX;
						OP_FX:   op_q <= OP_FY;
						OP_FY:   op_q <= OP_FZ;
						OP_FZ: begin
							fsel_q  <= 1'b0;
							state_q <= S_FRD;
						end
						OP_KICK: op_q <= OP_DV;
						OP_DV:   op_q <= OP_DA;
						OP_DA: begin
							if (comp_q == 2'd2) begin
								state_q <= S_AWR;
							end else begin
								comp_q <= comp_q + 2'd1;
								op_q   <= OP_KICK;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + DCW'(1);
					if (dcnt_q == DCW'(DIVN - 1)) begin
						op_q    <= OP_R4;
						mulk_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_FRD: begin
					state_q <= S_FWR;
				end
				S_FWR: begin
					if (!fsel_q) begin
						fsel_q  <= 1'b1;
						state_q <= S_FRD;
					end else begin
						fsel_q <= 1'b0;
						if (!last_j) begin
							j_q     <= j_q + IW'(1);
							state_q <= S_PRD;
						end else if (!last_i) begin
							i_q     <= i_q + IW'(1);
							j_q     <= i_q + IW'(2);
							state_q <= S_PRD;
						end else begin
							i_q     <= '0;
							state_q <= S_ARD;
						end
					end
				end
				S_ARD: begin
					state_q <= S_ALD;
				end
				S_ALD: begin
					comp_q  <= '0;
					op_q    <= OP_KICK;
					mulk_q  <= '0;
					state_q <= S_MUL;
				end
				S_AWR: begin
					if (last_adv) begin
						step_q  <= step_q + 16'd1;
						state_q <= S_STEP;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_ARD;
					end
				end
				S_ORD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					strobe_q <= 1'b1;
					if (last_adv) begin
						state_q <= S_IDLE;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_ORD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_DIFF: begin
				d_q[0] <= 33'(rda_q.x) - 33'(rdb_q.x);
				d_q[1] <= 33'(rda_q.y) - 33'(rdb_q.y);
				d_q[2] <= 33'(rda_q.z) - 33'(rdb_q.z);
			end
			S_MUL: begin
				acc_q <= ((mulk_q == 2'd0) ? '0 : acc_q) + pp_sh;
			end
			S_POST: begin
				case (op_q)
					OP_SQX:  r2_q <= sq;
					OP_SQY:  r2_q <= r2_sum;
					OP_SQZ:  r2_q <= (r2_sum < R2_MIN) ? R2_MIN : r2_sum;
					OP_R4:   r4_q <= sh_q[R4W-1:0];
					OP_R8:   r8_q <= sh_q[R8W-1:0];
					OP_R12:  t_q <= sh_q[TW-1:0];
					OP_R14:  c_q <= $signed(c_calc);
					OP_FX:   f_q[0] <= fval;
					OP_FY:   f_q[1] <= fval;
					OP_FZ:   f_q[2] <= fval;
					OP_KICK: begin
						kick_q <= sc;
						vl_q[comp_q] <= sat32(49'(vl_q[comp_q]) + 49'(sc));
					end
					OP_DV:   sv_q <= sc;
					OP_DA: begin
						px_q[comp_q] <= sat32(49'(px_q[comp_q]) + 49'(sv_q) + 49'(sc));
						vl_q[comp_q] <= sat32(49'(vl_q[comp_q]) + 49'(kick_q));
					end
					default: r2_q <= r2_q;
				endcase
			end
			S_DIV: begin
				if (div_ge) begin
					rem_q <= R2W'(div_sh - {1'b0, r2_q});
					inv_q <= {inv_q[INVW-2:0], 1'b1};
				end else begin
					rem_q <= div_sh[R2W-1:0];
					inv_q <= {inv_q[INVW-2:0], 1'b0};
				end
				if (dcnt_q == '0) begin
					inv_q <= INVW'(div_ge);
				end
			end
			S_ALD: begin
				px_q[0] <= rda_q.x;
				px_q[1] <= rda_q.y;
				px_q[2] <= rda_q.z;
				vl_q[0] <= vrd_q.x;
				vl_q[1] <= vrd_q.y;
				vl_q[2] <= vrd_q.z;
				ac_q[0] <= fvld_q ? frd_q.x : '0;
				ac_q[1] <= fvld_q ? frd_q.y : '0;
				ac_q[2] <= fvld_q ? frd_q.z : '0;
			end
			S_OUT: begin
				result_q.new_pos_x <= rda_q.x;
				result_q.new_pos_y <= rda_q.y;
				result_q.new_pos_z <= rda_q.z;
				result_q.new_vel_x <= vrd_q.x;
				result_q.new_vel_y <= vrd_q.y;
				result_q.new_vel_z <= vrd_q.z;
				result_q.out_last  <= last_adv;
			end
			default: acc_q <= acc_q;
		endcase
	end

	// A result transaction comes only from the output state.
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(state_q == S_OUT))
		else $error("result strobe without output state");

	// A particle that finds room in the store raises the count by one.
	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !item.in_last && room) |=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("particle count did not advance");

	// The divider never sees a distance below the clamp.
	a_r2_min: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (r2_q >= R2_MIN))
		else $error("r2 below minimum in divider");

endmodule

/* verif/lennard_jones_nbody_timestep_checker.sv */
`timescale 1ns / 1ps

// Watches the load, result and register channels, predicts every emitted particle and
// compares it with what the block strobes out.
module lennard_jones_nbody_timestep_checker
	import ljnb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  in_item_t  item,
	input  logic      result_strobe,
	input  out_item_t result,
	input  logic      cfg_we,
	input  logic [15:0] cfg_wdata,
	output int        errors,
	output int        pending
);

	localparam int NP = PARTICLES_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam longint FORCE_LIM = (longint'(1) << 47) - 1;
	localparam longint WORD_LIM = 64'sd2147483647;
	localparam longint unsigned SCALE_CAP = 64'd1 << 62;

	// Shadow copy of the particle set and the step register.
	longint px[NP], py[NP], pz[NP];
	longint vx[NP], vy[NP], vz[NP];
	longint fx[NP], fy[NP], fz[NP];
	int steps_cfg;
	int held;
	out_item_t expected_particles[$];

	assign pending = expected_particles.size();

	function automatic longint clamp(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim - 1) return -lim - 1;
		return v;
	endfunction

	function automatic longint unsigned mag(longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	// Floor of a*b >> s, saturated to cap.
	function automatic longint unsigned mul_shr(longint unsigned a, longint unsigned b, int s,
			longint unsigned cap);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> s;
		if (p[127:64] != 0 || p[63:0] > cap) return cap;
		return p[63:0];
	endfunction

	function automatic longint scale_q32(longint x, longint unsigned k);
		longint r;
		r = longint'(mul_shr(mag(x), k, 32, SCALE_CAP));
		return x < 0 ? -r : r;
	endfunction

	function automatic longint pair_component(longint c, longint d);
		longint r;
		r = longint'(mul_shr(mag(c), mag(d), INV_Q, FORCE_LIM));
		return ((c < 0) != (d < 0)) ? -r : r;
	endfunction

	// Lennard-Jones force between particles i and j, equal and opposite.
	function automatic void lj_pair(int i, int j);
		longint dx, dy, dz, c, gx, gy, gz;
		longint unsigned r2, inv, r4, r8, r14;
		dx = px[i] - px[j];
		dy = py[i] - py[j];
		dz = pz[i] - pz[j];
		r2 = ((mag(dx) * mag(dx)) >> FB) + ((mag(dy) * mag(dy)) >> FB)
			+ ((mag(dz) * mag(dz)) >> FB);
		if (r2 < (64'd1 << (FB - 1))) r2 = 64'd1 << (FB - 1);
		inv = (64'd1 << (INV_Q + FB)) / r2;
		r4 = (inv * inv) >> INV_Q;
		r8 = (r4 * r4) >> INV_Q;
		r14 = (((r8 * r4) >> INV_Q) * inv) >> INV_Q;
		c = longint'(48 * r14) - longint'(24 * r8);
		gx = pair_component(c, dx);
		gy = pair_component(c, dy);
		gz = pair_component(c, dz);
		fx[i] = clamp(fx[i] + gx, FORCE_LIM);
		fy[i] = clamp(fy[i] + gy, FORCE_LIM);
		fz[i] = clamp(fz[i] + gz, FORCE_LIM);
		fx[j] = clamp(fx[j] - gx, FORCE_LIM);
		fy[j] = clamp(fy[j] - gy, FORCE_LIM);
		fz[j] = clamp(fz[j] - gz, FORCE_LIM);
	endfunction

	// Half kick, drift, half kick with the same force, then clear the force.
	function automatic void verlet_axis(inout longint x, inout longint v, inout longint a);
		longint kick;
		kick = scale_q32(a, HALF_DT_Q32);
		v = clamp(v + kick, WORD_LIM);
		x = clamp(x + scale_q32(v, DT_Q32) + scale_q32(a, HALF_DT2_Q32), WORD_LIM);
		v = clamp(v + kick, WORD_LIM);
		a = 0;
	endfunction

	// Runs the configured number of steps over the held set and queues its particles.
	function automatic void run_particle_set();
		out_item_t o;
		for (int s = 0; s < steps_cfg; s++) begin
			for (int i = 0; i < held; i++)
				for (int j = i + 1; j < held; j++)
					lj_pair(i, j);
			for (int i = 0; i < held; i++) begin
				verlet_axis(px[i], vx[i], fx[i]);
				verlet_axis(py[i], vy[i], fy[i]);
				verlet_axis(pz[i], vz[i], fz[i]);
			end
		end
		for (int i = 0; i < held; i++) begin
			o.new_pos_x = px[i][31:0];
			o.new_pos_y = py[i][31:0];
			o.new_pos_z = pz[i][31:0];
			o.new_vel_x = vx[i][31:0];
			o.new_vel_y = vy[i][31:0];
			o.new_vel_z = vz[i][31:0];
			o.out_last = (i + 1 == held);
			expected_particles.push_back(o);
		end
		held = 0;
	endfunction

	task automatic report(string field, longint got, longint want);
		if (errors < 40)
			$display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
		errors++;
	endtask

	// Track every load transaction and register write, and predict when the last item is loaded.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			steps_cfg = 1;
			expected_particles.delete();
			for (int i = 0; i < NP; i++) begin
				fx[i] = 0;
				fy[i] = 0;
				fz[i] = 0;
			end
		end else begin
			if (cfg_we)
				steps_cfg = cfg_wdata;
			if (start && !busy) begin
				if (held < NP) begin
					px[held] = item.pos_x;
					py[held] = item.pos_y;
					pz[held] = item.pos_z;
					vx[held] = item.vel_x;
					vy[held] = item.vel_y;
					vz[held] = item.vel_z;
					held++;
				end
				if (item.in_last)
					run_particle_set();
			end
		end
	end

	// Compare each result transaction with the oldest expected particle.
	initial errors = 0;
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && result_strobe) begin
			if (expected_particles.size() == 0) begin
				report("unexpected result", result, 0);
			end else begin
				e = expected_particles.pop_front();
				if (result.new_pos_x !== e.new_pos_x) report("new_pos_x", result.new_pos_x, e.new_pos_x);
				if (result.new_pos_y !== e.new_pos_y) report("new_pos_y", result.new_pos_y, e.new_pos_y);
				if (result.new_pos_z !== e.new_pos_z) report("new_pos_z", result.new_pos_z, e.new_pos_z);
				if (result.new_vel_x !== e.new_vel_x) report("new_vel_x", result.new_vel_x, e.new_vel_x);
				if (result.new_vel_y !== e.new_vel_y) report("new_vel_y", result.new_vel_y, e.new_vel_y);
				if (result.new_vel_z !== e.new_vel_z) report("new_vel_z", result.new_vel_z, e.new_vel_z);
				if (result.out_last !== e.out_last) report("out_last", result.out_last, e.out_last);
			end
		end
	end

endmodule

/* verif/lennard_jones_nbody_timestep_test.sv */
`timescale 1ns / 1ps

module lennard_jones_nbody_timestep_test;
	import ljnb_pkg::*;

	localparam longint CYCLE_LIMIT = 20_000_000;
	localparam int RANDOM_ITEMS = 330;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t item = '0;
	logic result_strobe;
	out_item_t result;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	int errors;
	int pending;
	int idle_pct = 0;
	int sent = 0;
	longint cycles = 0;

	always #2 clk = ~clk;

	lennard_jones_nbody_timestep uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_strobe(result_strobe), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	lennard_jones_nbody_timestep_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_strobe(result_strobe), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending)
	);

	// Give up on a hung block.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("lennard_jones_nbody_timestep verification failed");
			$finish;
		end
	end

	// Holds a load transaction until it is taken, idling at random meanwhile.
	task automatic load(in_item_t it);
		forever begin
			@(negedge clk);
			if ($urandom_range(99) < idle_pct) begin
				start = 1'b0;
			end else begin
				start = 1'b1;
				item = it;
				if (!busy) break;
			end
		end
		sent++;
	endtask

	// Waits until every expected particle has come and the block is quiet.
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (pending != 0 || busy) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic set_steps(logic [15:0] n);
		settle();
		cfg_we = 1'b1;
		cfg_wdata = n;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic in_item_t particle(bit noisy, logic signed [31:0] base, bit last);
		in_item_t p;
		if (noisy) begin
			p.pos_x = $urandom; p.pos_y = $urandom; p.pos_z = $urandom;
			p.vel_x = $urandom; p.vel_y = $urandom; p.vel_z = $urandom;
		end else begin
			// Cluster within about two units so that the forces matter.
			p.pos_x = base + $signed($urandom_range(262143)) - 131072;
			p.pos_y = base + $signed($urandom_range(262143)) - 131072;
			p.pos_z = base + $signed($urandom_range(262143)) - 131072;
			p.vel_x = $signed($urandom_range(131071)) - 65536;
			p.vel_y = $signed($urandom_range(131071)) - 65536;
			p.vel_z = $signed($urandom_range(131071)) - 65536;
		end
		p.in_last = last;
		return p;
	endfunction

	initial begin
		in_item_t p;
		int n;
		logic signed [31:0] base;
		bit noisy;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Extreme fields with the reset step count.
		p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 1'b0};
		load(p);
		p = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 1'b1};
		load(p);
		// Coincident particles, then a very close pair with a third particle.
		p = '{32'sh10000, 32'sh20000, -32'sh30000, 32'sh100, 0, 0, 1'b0};
		load(p);
		p.in_last = 1'b1;
		load(p);
		p = '{0, 0, 0, 0, 0, 0, 1'b0};
		load(p);
		p = '{32'sh40, -32'sh40, 32'sh1, 0, 0, 0, 1'b0};
		load(p);
		p = '{32'sh18000, 0, 0, 0, 0, 0, 1'b1};
		load(p);
		// A zero step count emits the set unchanged.
		set_steps(16'd0);
		load(particle(1, 0, 0));
		load(particle(1, 0, 1));
		// The largest step count on a lone particle.
		set_steps(16'hffff);
		p = '{32'sh7fff0000, -32'sh7fff0000, 0, 32'sh10000000, -32'sh10000000, 32'sh123, 1'b1};
		load(p);
		set_steps(16'd2);
		p = particle(0, 0, 0);
		load(p);
		load(particle(0, 0, 1));

		// Random sets: mostly clustered, some noise, one full store with an overflow item.
		idle_pct = 21;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent > RANDOM_ITEMS / 3) idle_pct = 78;
			if (sent > 2 * RANDOM_ITEMS / 3) idle_pct = 0;
			if ($urandom_range(4) == 0) set_steps($urandom_range(3, 1));
			if ($urandom_range(5) == 0) settle();
			if (sent > RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + 8) begin
				set_steps(16'd1);
				for (int i = 0; i < 64; i++) load(particle(0, 0, 0));
				load(particle(0, 0, 1));
			end else begin
				n = $urandom_range(6, 1);
				noisy = ($urandom_range(5) == 0);
				base = $urandom;
				for (int i = 0; i < n; i++) load(particle(noisy, base, i == n - 1));
			end
		end

		settle();
		if (errors == 0)
			$display("lennard_jones_nbody_timestep verification clean");
		else
			$display("lennard_jones_nbody_timestep verification failed");
		$finish;
	end

endmodule
